// ===== rtl/ifla_pkg.sv =====
// shared types and constants for the index free-list allocator
// no dependencies
package ifla_pkg;

	// number of slots; index and count widths follow from it
	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int STAT_W  = 2;
	localparam int USE_W   = $clog2(ENTRIES + 1);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// registered result of one request, which drives the outputs of the top level
	typedef struct packed {
		logic              valid;
		logic              give;
		logic              from_mem;
		logic [IDX_W-1:0]  dflt;
		logic [STAT_W-1:0] status;
		logic [USE_W-1:0]  in_use;
	} ifla_res_t;

endpackage

// ===== rtl/index_free_list_allocator_unit.sv =====
// top level of the index free-list allocator
// depends on ifla_pkg, ifla_ctrl and ifla_ring_mem
//
// usage:
//  - a request is taken at a rising edge with start high and busy low; command
//    0 allocates the oldest free index, command 1 returns free_index to the tail
//  - busy never rises: one request is taken every cycle
//  - the result appears in the cycle after the request, for exactly one cycle,
//    marked by done: alloc_index (0 unless an allocate succeeded), status
//    (0 ok, 1 allocate while empty, 2 free while full) and in_use after it
//  - a failed request leaves the list untouched
//  - the result is registered, as is the read of the ring memory;
//    throughput is one request per cycle, each a single pointer update
//  - after reset the ring holds 0 .. ENTRIES-1 in order and all are free;
//    no clearing pass is needed, a fill count marks which slots still read as
//    their slot number
//  - the receiver cannot stall; a result not taken in its cycle is gone
module index_free_list_allocator_unit
	import ifla_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic [IDX_W-1:0]  free_index,
	output logic              done,
	output logic [IDX_W-1:0]  alloc_index,
	output logic [STAT_W-1:0] status,
	output logic [USE_W-1:0]  in_use
);

	localparam int PTR_W = IDX_W;

	logic             accept;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	logic [IDX_W-1:0] wr_data;
	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic [IDX_W-1:0] rd_data_s1;
	ifla_res_t        res_s1;

	// every request is a single pointer update, never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	ifla_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (command),
		.free_index (free_index),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.res_s1     (res_s1)
	);

	ifla_ring_mem #(
		.DEPTH  (ENTRIES),
		.ADDR_W (PTR_W)
	) u_mem (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data_s1 (rd_data_s1)
	);

	always_comb begin
		done   = res_s1.valid;
		status = res_s1.status;
		in_use = res_s1.in_use;
		if (res_s1.give) begin
			alloc_index = res_s1.from_mem ? rd_data_s1 : res_s1.dflt;
		end else begin
			alloc_index = '0;
		end
	end

endmodule

// ===== rtl/ifla_ring_mem.sv =====
// ring storage of free indices: one write port, one read port, registered read
// depends on ifla_pkg
module ifla_ring_mem
	import ifla_pkg::*;
#(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [IDX_W-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [IDX_W-1:0]  rd_data_s1
);

	logic [IDX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/ifla_ctrl.sv =====
// pointer, count and fill tracking for the free-index ring
// depends on ifla_pkg; drives the ports of ifla_ring_mem
module ifla_ctrl
	import ifla_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             command,
	input  logic [IDX_W-1:0] free_index,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_addr,
	output logic [IDX_W-1:0] wr_data,
	output logic             rd_en,
	output logic [IDX_W-1:0] rd_addr,
	output ifla_res_t        res_s1
);

	localparam int PTR_W = IDX_W;
	localparam int CNT_W = USE_W;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ENTRIES - 1);

	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] free_cnt_q;
	// entries below fill_q have been written since reset
	logic [CNT_W-1:0] fill_q;

	logic             do_alloc;
	logic             do_free;
	logic [CNT_W-1:0] free_cnt_nxt;
	logic [STAT_W-1:0] status;

	always_comb begin
		do_alloc     = 1'b0;
		do_free      = 1'b0;
		status       = ST_OK;
		free_cnt_nxt = free_cnt_q;
		if (accept) begin
			if (command == CMD_ALLOC) begin
				if (free_cnt_q == '0) begin
					status = ST_EMPTY;
				end else begin
					do_alloc     = 1'b1;
					free_cnt_nxt = free_cnt_q - CNT_W'(1);
				end
			end else begin
				if (free_cnt_q == FULL_CNT) begin
					status = ST_FULL;
				end else begin
					do_free      = 1'b1;
					free_cnt_nxt = free_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	assign wr_en   = do_free;
	assign wr_addr = wr_ptr_q;
	assign wr_data = free_index;
	assign rd_en   = do_alloc;
	assign rd_addr = rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			free_cnt_q <= FULL_CNT;
			fill_q     <= '0;
			res_s1     <= '0;
		end else begin
			free_cnt_q <= free_cnt_nxt;
			if (do_alloc) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_free) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
				if (fill_q != FULL_CNT) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			res_s1.valid    <= accept;
			res_s1.give     <= do_alloc;
			// unwritten entries still hold their reset value, the slot number
			res_s1.from_mem <= (CNT_W'(rd_ptr_q) < fill_q);
			res_s1.dflt     <= IDX_W'(rd_ptr_q);
			res_s1.status   <= status;
			res_s1.in_use   <= USE_W'(FULL_CNT - free_cnt_nxt);
		end
	end

endmodule

// ===== dv/ifla_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the index free-list allocator: tracks its own copy of the free ring,
// predicts every grant and compares it with the one the block returns; depends on ifla_pkg
module ifla_checker
	import ifla_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              command,
	input  logic [IDX_W-1:0]  free_index,
	input  logic              done,
	input  logic [IDX_W-1:0]  alloc_index,
	input  logic [STAT_W-1:0] status,
	input  logic [USE_W-1:0]  in_use,
	output int                errors,
	output int                pending,
	output int                grants_seen,
	output int                empty_hits,
	output int                full_hits
);

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [STAT_W-1:0] st;
		logic [USE_W-1:0]  used;
	} grant_t;

	logic [IDX_W-1:0] free_ring [ENTRIES];
	int               head;
	int               tail;
	int               free_cnt;
	grant_t           expected_grants [$];

	task automatic clear_list();
		for (int i = 0; i < ENTRIES; i++) free_ring[i] = IDX_W'(i);
		head = 0;
		tail = 0;
		free_cnt = ENTRIES;
		expected_grants.delete();
	endtask

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
	endtask

	// one request against the model list; rejected requests leave it alone
	function automatic grant_t allocator_step(logic cmd, logic [IDX_W-1:0] idx);
		grant_t g;
		g = '0;
		g.st = ST_OK;
		if (cmd == CMD_ALLOC) begin
			if (free_cnt == 0) begin
				g.st = ST_EMPTY;
			end else begin
				g.idx = free_ring[head];
				head = (head + 1) % ENTRIES;
				free_cnt--;
			end
		end else begin
			if (free_cnt >= ENTRIES) begin
				g.st = ST_FULL;
			end else begin
				free_ring[tail] = idx;
				tail = (tail + 1) % ENTRIES;
				free_cnt++;
			end
		end
		g.used = USE_W'(ENTRIES - free_cnt);
		return g;
	endfunction

	initial begin
		errors = 0;
		grants_seen = 0;
		empty_hits = 0;
		full_hits = 0;
		pending = 0;
		clear_list();
	end

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			clear_list();
		end else begin
			// results first: the one leaving now belongs to an earlier request
			if (done) begin
				if (expected_grants.size() == 0) begin
					report_mismatch("outstanding request count", 0, 1);
				end else begin
					want = expected_grants.pop_front();
					grants_seen++;
					if (want.st == ST_EMPTY) empty_hits++;
					if (want.st == ST_FULL) full_hits++;
					if (alloc_index !== want.idx)
						report_mismatch("alloc_index", alloc_index, want.idx);
					if (status !== want.st)
						report_mismatch("status", status, want.st);
					if (in_use !== want.used)
						report_mismatch("in_use", in_use, want.used);
				end
			end
			if (start && !busy)
				expected_grants.push_back(allocator_step(command, free_index));
		end
		pending = expected_grants.size();
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// testbench top for index_free_list_allocator_unit: drives allocate and free requests
// with random gaps and gives the verdict; depends on ifla_pkg and ifla_checker
module tb;
	import ifla_pkg::*;

	localparam int N_REQUESTS  = 1350;
	localparam int STALL_LIMIT = 500;

	typedef enum {DRAIN, FILL, MIXED, ALLOC_BURST, FREE_BURST} phase_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              command;
	logic [IDX_W-1:0]  free_index;
	logic              done;
	logic [IDX_W-1:0]  alloc_index;
	logic [STAT_W-1:0] status;
	logic [USE_W-1:0]  in_use;

	int errors;
	int pending;
	int grants_seen;
	int empty_hits;
	int full_hits;
	int sent;
	int stall_cycles;

	index_free_list_allocator_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.free_index  (free_index),
		.done        (done),
		.alloc_index (alloc_index),
		.status      (status),
		.in_use      (in_use)
	);

	ifla_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.free_index  (free_index),
		.done        (done),
		.alloc_index (alloc_index),
		.status      (status),
		.in_use      (in_use),
		.errors      (errors),
		.pending     (pending),
		.grants_seen (grants_seen),
		.empty_hits  (empty_hits),
		.full_hits   (full_hits)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ends the run when neither a request nor a result moves for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no activity for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send(logic cmd, logic [IDX_W-1:0] idx);
		start <= 1'b1;
		command <= cmd;
		free_index <= idx;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// edge indices show up often, the rest uniform
	function automatic logic [IDX_W-1:0] pick_index();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return IDX_W'($urandom_range(0, ENTRIES - 1));
	endfunction

	initial begin
		phase_t mode;
		int     phase_len;
		int     alloc_pct;
		bit     calm;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_ALLOC;
		free_index = '0;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// list starts full, so frees are rejected
		send(CMD_FREE, '0);
		send(CMD_FREE, '1);
		send(CMD_ALLOC, '0);
		send(CMD_ALLOC, '1);
		send(CMD_ALLOC, '0);
		// refill to full, the last free is rejected again
		send(CMD_FREE, '1);
		send(CMD_FREE, '0);
		send(CMD_FREE, 6'h2a);
		send(CMD_FREE, 6'h15);
		// freed indices come back after the untouched ones
		repeat (4) send(CMD_ALLOC, '0);
		send(CMD_FREE, 6'h2a);
		pause(3);

		// phases push the list to empty and back to full, across ring wraps
		while (sent < N_REQUESTS) begin
			mode = phase_t'($urandom_range(0, 4));
			phase_len = $urandom_range(20, 120);
			calm = ($urandom_range(0, 3) == 0);
			case (mode)
				DRAIN: alloc_pct = 90;
				FILL: alloc_pct = 10;
				MIXED: alloc_pct = 50;
				ALLOC_BURST: begin
					alloc_pct = 100;
					phase_len = ENTRIES + 6;
				end
				default: begin
					alloc_pct = 0;
					phase_len = ENTRIES + 6;
				end
			endcase
			repeat (phase_len) begin
				if ($urandom_range(0, 99) < alloc_pct)
					send(CMD_ALLOC, IDX_W'($urandom_range(0, ENTRIES - 1)));
				else
					send(CMD_FREE, pick_index());
				if (!calm) pause(gap_len());
			end
		end

		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(posedge clk);

		$display("run covered %0d requests and %0d results", sent, grants_seen);
		$display("rejections seen: %0d allocates on an empty list, %0d frees on a full one",
			empty_hits, full_hits);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
